// ===== rtl/swb_pkg.sv =====
// Shared constants for the sliding window band unit.
`timescale 1ns / 1ps
package swb_pkg;

	localparam int DEF_MAX_WINDOW = 64;
	localparam int DEF_PRICE_BITS = 24;

	localparam int LEN_W  = 7;
	localparam int BWID_W = 12;
	localparam int BAND_W = 40;
	localparam int MEAN_W = 32;
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam logic [LEN_W-1:0]  WLEN_RST = 7'd20;
	localparam logic [BWID_W-1:0] BWID_RST = 12'd512;
	localparam logic              BSEL_RST = 1'b1;

	localparam logic [1:0] REG_WLEN = 2'd0;
	localparam logic [1:0] REG_BWID = 2'd1;
	localparam logic [1:0] REG_BSEL = 2'd2;

endpackage

// ===== rtl/sliding_window_band_unit.sv =====
// Sliding window band unit: window ring, running sums and the serial arithmetic sequencer.
// Each accepted price runs in sequence through shift-add multiplies (one multiplier bit per cycle),
// a 31-step root and a 45-step divide; while the window is filling, only the two squares are formed.
// One transaction at a time: the next price is taken only once the last one is done or dropped;
// a stalled result holds the next one in sequence.
// Reset clears window state and loads the register defaults; ring entries are not cleared.
`timescale 1ns / 1ps
module sliding_window_band_unit
	import swb_pkg::*;
#(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW,
	parameter int PRICE_BITS = DEF_PRICE_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_AW-1:0]        paddr,
	input  logic [APB_DW-1:0]        pwdata,
	output logic [APB_DW-1:0]        prdata,
	output logic                     pready,
	input  logic [PRICE_BITS-1:0]    price,
	input  logic                     price_valid,
	output logic                     price_ready,
	output logic signed [BAND_W-1:0] band_value,
	output logic [MEAN_W-1:0]        mean_value,
	output logic                     band_valid,
	input  logic                     band_ready
);

	localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SUM_W = PRICE_BITS + LEN_W;
	localparam int SQ_W  = 2 * PRICE_BITS + LEN_W;
	localparam int DW    = 2 * PRICE_BITS + 2 * LEN_W;
	localparam int RW    = DW / 2;
	localparam int NUMW  = RW + BWID_W + 2;
	localparam logic signed [63:0] BMAX = (64'sd1 <<< (BAND_W - 1)) - 64'sd1;
	localparam logic signed [63:0] BMIN = -BMAX - 64'sd1;

	typedef enum logic [3:0] {
		S_IDLE, S_PP, S_OO, S_LS, S_SS, S_SQ, S_BW, S_DV, S_OUT
	} state_t;

	state_t state_q;

	logic [LEN_W-1:0]  wlen_q;
	logic [BWID_W-1:0] bwid_q;
	logic              bsel_q;
	logic              cfg_wr;
	logic              restart;

	logic [PTR_W-1:0]      wp_q;
	logic [LEN_W-1:0]      fill_q;
	logic [SUM_W-1:0]      sum_q;
	logic [SQ_W-1:0]       sq_q;
	logic [PRICE_BITS-1:0] ring [MAX_WINDOW];
	logic [PRICE_BITS-1:0] rd_q;
	logic [PRICE_BITS-1:0] p_q;
	logic                  full_q;
	logic [DW-1:0]         psq_q;
	logic [DW-1:0]         lsq_q;

	logic             mstart_q;
	logic [DW-1:0]    ma_q;
	logic [SUM_W-1:0] mb_q;
	logic             mdone;
	logic [DW-1:0]    mprod;
	logic             sstart_q;
	logic [DW-1:0]    d_q;
	logic             sdone;
	logic [RW-1:0]    sroot;
	logic             dstart_q;
	logic [NUMW-1:0]  bnum_q;
	logic [NUMW-1:0]  mnum_q;
	logic             neg_q;
	logic             bdone;
	logic [NUMW-1:0]  bq;
	logic             mdiv_done;
	logic [NUMW-1:0]  mq;

	logic signed [BAND_W-1:0] band_q;
	logic [MEAN_W-1:0]        mean_q;
	logic                     ovalid_q;

	logic                  accept;
	logic [LEN_W-1:0]      len_c;
	logic [PTR_W-1:0]      slot_c;
	logic [PTR_W-1:0]      wp_nx;
	logic [PRICE_BITS-1:0] old_c;
	logic [SUM_W-1:0]      sum_nx;
	logic [SQ_W-1:0]       sq_nx;
	logic [DW-1:0]         dd_c;
	logic [NUMW-1:0]       ns_c;
	logic [NUMW-1:0]       pb_c;
	logic [NUMW-1:0]       num_c;
	logic [NUMW-1:0]       mag_c;
	logic signed [63:0]    bv_c;
	logic signed [63:0]    sat_c;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign restart = cfg_wr && (paddr[3:2] == REG_WLEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RST;
			bwid_q <= BWID_RST;
			bsel_q <= BSEL_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_WLEN: wlen_q <= pwdata[LEN_W-1:0];
				REG_BWID: bwid_q <= pwdata[BWID_W-1:0];
				REG_BSEL: bsel_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WLEN: prdata = APB_DW'(wlen_q);
			REG_BWID: prdata = APB_DW'(bwid_q);
			REG_BSEL: prdata = APB_DW'(bsel_q);
			default:  prdata = '0;
		endcase
	end

	// effective window length and ring slot
	always_comb begin
		if (wlen_q == '0) begin
			len_c = LEN_W'(1);
		end else if (32'(wlen_q) > MAX_WINDOW) begin
			len_c = LEN_W'(MAX_WINDOW);
		end else begin
			len_c = wlen_q;
		end
		slot_c = (32'(wp_q) >= 32'(len_c)) ? '0 : wp_q;
		wp_nx  = (32'(slot_c) + 1 >= 32'(len_c)) ? '0 : slot_c + 1'b1;
	end

	assign accept      = price_valid && price_ready;
	assign price_ready = (state_q == S_IDLE);

	always_comb begin
		old_c  = full_q ? rd_q : '0;
		sum_nx = sum_q - SUM_W'(old_c) + SUM_W'(p_q);
		sq_nx  = sq_q - SQ_W'(mprod) + SQ_W'(psq_q);
		dd_c   = (lsq_q > mprod) ? lsq_q - mprod : '0;
		ns_c   = NUMW'(sum_q) << 8;
		pb_c   = NUMW'(mprod);
		num_c  = bsel_q ? ns_c + pb_c : ns_c - pb_c;
		mag_c  = num_c[NUMW-1] ? -num_c : num_c;
		bv_c   = neg_q ? -signed'(64'(bq)) : signed'(64'(bq));
		if (bv_c > BMAX) begin
			sat_c = BMAX;
		end else if (bv_c < BMIN) begin
			sat_c = BMIN;
		end else begin
			sat_c = bv_c;
		end
	end

	// ring memory, read of the outgoing price before it is overwritten
	always_ff @(posedge clk) begin
		if (accept) begin
			ring[slot_c] <= price;
			rd_q         <= ring[slot_c];
			p_q          <= price;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			wp_q     <= '0;
			fill_q   <= '0;
			sum_q    <= '0;
			sq_q     <= '0;
			full_q   <= 1'b0;
			mstart_q <= 1'b0;
			sstart_q <= 1'b0;
			dstart_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			mstart_q <= 1'b0;
			sstart_q <= 1'b0;
			dstart_q <= 1'b0;
			if (ovalid_q && band_ready) begin
				ovalid_q <= 1'b0;
			end
			if (restart) begin
				wp_q   <= '0;
				fill_q <= '0;
				sum_q  <= '0;
				sq_q   <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						full_q <= (fill_q >= len_c);
						fill_q <= (fill_q >= len_c) ? len_c : fill_q + 1'b1;
						wp_q   <= wp_nx;
						ma_q   <= DW'(price);
						mb_q   <= SUM_W'(price);
						mstart_q <= 1'b1;
						state_q  <= S_PP;
					end
				end
				S_PP: begin
					if (mdone) begin
						psq_q    <= mprod;
						ma_q     <= DW'(old_c);
						mb_q     <= SUM_W'(old_c);
						mstart_q <= 1'b1;
						state_q  <= S_OO;
					end
				end
				S_OO: begin
					if (mdone) begin
						sum_q <= sum_nx;
						sq_q  <= sq_nx;
						// drop the item quietly until the window is full
						if (fill_q < len_c) begin
							state_q <= S_IDLE;
						end else begin
							ma_q     <= DW'(sq_nx);
							mb_q     <= SUM_W'(len_c);
							mstart_q <= 1'b1;
							state_q  <= S_LS;
						end
					end
				end
				S_LS: begin
					if (mdone) begin
						lsq_q    <= mprod;
						ma_q     <= DW'(sum_q);
						mb_q     <= sum_q;
						mstart_q <= 1'b1;
						state_q  <= S_SS;
					end
				end
				S_SS: begin
					if (mdone) begin
						d_q      <= dd_c;
						sstart_q <= 1'b1;
						state_q  <= S_SQ;
					end
				end
				S_SQ: begin
					if (sdone) begin
						ma_q     <= DW'(sroot);
						mb_q     <= SUM_W'(bwid_q);
						mstart_q <= 1'b1;
						state_q  <= S_BW;
					end
				end
				S_BW: begin
					if (mdone) begin
						bnum_q   <= mag_c;
						neg_q    <= num_c[NUMW-1];
						mnum_q   <= ns_c;
						dstart_q <= 1'b1;
						state_q  <= S_DV;
					end
				end
				S_DV: begin
					// both dividers run the same number of steps
					if (bdone && mdiv_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the output register is free
					if (!ovalid_q || band_ready) begin
						band_q   <= BAND_W'(sat_c);
						mean_q   <= MEAN_W'(mq);
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	swb_mul #(.AW(DW), .BW(SUM_W)) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mstart_q),
		.a     (ma_q),
		.b     (mb_q),
		.done  (mdone),
		.prod  (mprod)
	);

	swb_isqrt #(.DW(DW)) u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sstart_q),
		.d     (d_q),
		.done  (sdone),
		.root  (sroot)
	);

	swb_div #(.NW(NUMW)) u_div_band (
		.clk   (clk),
		.arst_n(arst_n),
		.start (dstart_q),
		.n     (bnum_q),
		.dv    (len_c),
		.done  (bdone),
		.q     (bq)
	);

	swb_div #(.NW(NUMW)) u_div_mean (
		.clk   (clk),
		.arst_n(arst_n),
		.start (dstart_q),
		.n     (mnum_q),
		.dv    (len_c),
		.done  (mdiv_done),
		.q     (mq)
	);

	assign band_value = band_q;
	assign mean_value = mean_q;
	assign band_valid = ovalid_q;

endmodule

// ===== rtl/swb_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle, stops early once the remaining multiplier bits are zero.
`timescale 1ns / 1ps
module swb_mul #(
	parameter int AW = 62,
	parameter int BW = 31
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	output logic          done,
	output logic [AW-1:0] prod
);

	logic          busy_q;
	logic          done_q;
	logic [AW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic [AW-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (b_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ===== rtl/swb_isqrt.sv =====
// Floor square root, one result bit per cycle.
`timescale 1ns / 1ps
module swb_isqrt #(
	parameter int DW = 62
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DW-1:0]   d,
	output logic            done,
	output logic [DW/2-1:0] root
);

	logic          busy_q;
	logic          done_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] root_q;
	logic [DW-1:0] bit_q;
	logic [DW-1:0] trial;

	assign trial = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (bit_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= d;
			root_q <= '0;
			bit_q  <= DW'(1) << (DW - 2);
		end else if (busy_q && (bit_q != '0)) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = root_q[DW/2-1:0];

endmodule

// ===== rtl/swb_div.sv =====
// Restoring divider by the window length, one quotient bit per cycle.
`timescale 1ns / 1ps
module swb_div
	import swb_pkg::*;
#(
	parameter int NW = 45
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NW-1:0]    n,
	input  logic [LEN_W-1:0] dv,
	output logic             done,
	output logic [NW-1:0]    q
);

	localparam int CW = $clog2(NW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [NW-1:0]    n_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] dv_q;
	logic [LEN_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, n_q[NW-1]};
	assign ge    = trial >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n;
			dv_q  <= dv;
			rem_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= ge ? LEN_W'(trial - {1'b0, dv_q}) : trial[LEN_W-1:0];
			n_q   <= {n_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign q    = n_q;

endmodule

// ===== bench/swb_checker.sv =====
// Checker for the sliding window band unit: band prediction and result comparison.
`timescale 1ns / 1ps
module swb_checker
	import swb_pkg::*;
#(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW,
	parameter int PRICE_BITS = DEF_PRICE_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic                     pready,
	input  logic [APB_AW-1:0]        paddr,
	input  logic [APB_DW-1:0]        pwdata,
	input  logic [PRICE_BITS-1:0]    price,
	input  logic                     price_valid,
	input  logic                     price_ready,
	input  logic signed [BAND_W-1:0] band_value,
	input  logic [MEAN_W-1:0]        mean_value,
	input  logic                     band_valid,
	input  logic                     band_ready,
	output int                       fail_count,
	output int                       expected_left
);

	typedef struct packed {
		logic signed [BAND_W-1:0] band;
		logic [MEAN_W-1:0]        mean;
	} band_result_t;

	localparam longint BAND_MAX = (longint'(1) <<< (BAND_W - 1)) - 1;
	localparam longint BAND_MIN = -BAND_MAX - 1;

	band_result_t         expected_bands[$];
	logic [PRICE_BITS-1:0] prices[MAX_WINDOW];
	int unsigned          slot_ptr;
	int unsigned          fill;
	longint unsigned      price_sum;
	longint unsigned      square_sum;
	logic [LEN_W-1:0]     cfg_len;
	logic [BWID_W-1:0]    cfg_gain;
	logic                 cfg_upper;

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned b;
		root = 0;
		b = longint'(1) << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v = v - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic int unsigned active_len();
		if (cfg_len == 0)
			return 1;
		if (cfg_len > MAX_WINDOW)
			return MAX_WINDOW;
		return cfg_len;
	endfunction

	// Push one price into the window; queue a band when the window is full.
	task automatic accept_price(input logic [PRICE_BITS-1:0] p);
		int unsigned     len;
		int unsigned     slot;
		longint unsigned old, lsq, ssq, dev, root;
		longint          num, q;
		band_result_t    r;
		len = active_len();
		slot = (slot_ptr >= len) ? 0 : slot_ptr;
		if (fill >= len) begin
			old = prices[slot];
			price_sum -= old;
			square_sum -= old * old;
			fill = len;
		end else begin
			fill++;
		end
		prices[slot] = p;
		price_sum += longint'(p);
		square_sum += longint'(p) * longint'(p);
		slot_ptr = (slot + 1 >= len) ? 0 : slot + 1;
		if (fill < len)
			return;
		lsq = longint'(len) * square_sum;
		ssq = price_sum * price_sum;
		dev = (lsq > ssq) ? lsq - ssq : 0;
		root = floor_sqrt(dev);
		if (cfg_upper)
			num = longint'(price_sum << 8) + longint'(cfg_gain) * longint'(root);
		else
			num = longint'(price_sum << 8) - longint'(cfg_gain) * longint'(root);
		q = num / longint'(len);
		if (q > BAND_MAX)
			q = BAND_MAX;
		if (q < BAND_MIN)
			q = BAND_MIN;
		r.band = q[BAND_W-1:0];
		r.mean = ((price_sum << 8) / len);
		expected_bands = {expected_bands, r};
	endtask

	always @(posedge clk or negedge arst_n) begin
		band_result_t want;
		if (!arst_n) begin
			expected_bands.delete();
			slot_ptr = 0;
			fill = 0;
			price_sum = 0;
			square_sum = 0;
			cfg_len = WLEN_RST;
			cfg_gain = BWID_RST;
			cfg_upper = BSEL_RST;
			fail_count = 0;
			expected_left = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_AW-1:2])
				REG_WLEN: begin
					cfg_len = pwdata[LEN_W-1:0];
					slot_ptr = 0;
					fill = 0;
					price_sum = 0;
					square_sum = 0;
				end
				REG_BWID: cfg_gain = pwdata[BWID_W-1:0];
				REG_BSEL: cfg_upper = pwdata[0];
				default: ;
				endcase
			end
			// check the outgoing transaction before queueing a new prediction
			if (band_valid && band_ready) begin
				if (expected_bands.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("band transaction with nothing expected: band %0d mean %0d",
							band_value, mean_value);
				end else begin
					want = expected_bands.pop_front();
					if (want.band !== band_value || want.mean !== mean_value) begin
						fail_count++;
						if (fail_count <= 10)
							$display("band mismatch: band exp %0d got %0d, mean exp %0d got %0d",
								want.band, band_value, want.mean, mean_value);
					end
				end
			end
			if (price_valid && price_ready)
				accept_price(price);
			expected_left = expected_bands.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the sliding window band unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
	import swb_pkg::*;

	localparam int PB = DEF_PRICE_BITS;
	localparam int CYCLE_LIMIT = 1200000;
	localparam int SETTLE = 260;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_AW-1:0]        paddr = '0;
	logic [APB_DW-1:0]        pwdata = '0;
	logic [APB_DW-1:0]        prdata;
	logic                     pready;
	logic [PB-1:0]            price = '0;
	logic                     price_valid = 1'b0;
	logic                     price_ready;
	logic signed [BAND_W-1:0] band_value;
	logic [MEAN_W-1:0]        mean_value;
	logic                     band_valid;
	logic                     band_ready = 1'b0;
	int                       fail_count;
	int                       expected_left;
	logic                     no_gaps = 1'b0;
	int                       price_style = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	sliding_window_band_unit u_dut (.*);

	swb_checker u_check (.*);

	task automatic reg_write(input logic [1:0] idx, input logic [APB_DW-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Set all three registers; upper bits of the data are noise.
	task automatic configure(input int len, input int gain, input bit upper);
		reg_write(REG_WLEN, {$urandom} & ~32'h7f | len);
		reg_write(REG_BWID, {$urandom} & ~32'hfff | gain);
		reg_write(REG_BSEL, {$urandom} & ~32'h1 | upper);
	endtask

	task automatic send_price(input logic [PB-1:0] p);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			price_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		price = p;
		price_valid = 1'b1;
		do @(posedge clk); while (!price_ready);
		@(negedge clk);
	endtask

	// Drop valid, drain all results, then cover the latency of a silent item.
	task automatic drain();
		price_valid = 1'b0;
		while (expected_left != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [PB-1:0] pick_price();
		case (price_style)
		0: return PB'($urandom);
		1: return PB'($urandom_range(0, 255));
		2: return $urandom_range(0, 1) ? {PB{1'b1}} : '0;
		3: return PB'(24'h800000 + $urandom_range(0, 7));
		default: return PB'($urandom);
		endcase
	endfunction

	task automatic run_phase(input int count);
		no_gaps = ($urandom_range(0, 4) == 0);
		price_style = $urandom_range(0, 5);
		repeat (count) send_price(pick_price());
		drain();
	endtask

	initial begin
		band_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int stall;
			@(negedge clk);
			stall = no_gaps ? 0 : $urandom_range(0, 18);
			band_ready = 1'b0;
			repeat (stall) @(negedge clk);
			band_ready = 1'b1;
			do @(posedge clk); while (!band_valid);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(negedge clk);

		// directed: defaults, field extremes, flat window, alternating extremes
		for (int i = 0; i < 22; i++)
			send_price((i < 20) ? ((i % 2) ? {PB{1'b1}} : '0) : {PB{1'b1}});
		drain();
		configure(1, 0, 1'b0);
		send_price('0);
		send_price({PB{1'b1}});
		send_price(24'h5a5a5a);
		drain();
		configure(2, 4095, 1'b0);
		send_price('0);
		send_price({PB{1'b1}});
		send_price('0);
		drain();
		// zero acts as one, oversize acts as the full ring
		configure(0, 4095, 1'b1);
		run_phase(30);
		configure(127, 4095, 1'b0);
		run_phase(140);
		configure(64, 4095, 1'b1);
		run_phase(140);
		// gain and side change keep the window; unmapped address is dropped
		reg_write(REG_BWID, 32'd1);
		reg_write(REG_BSEL, 32'd0);
		reg_write(2'd3, 32'hffffffff);
		run_phase(40);
		configure(3, 0, 1'b1);
		run_phase(60);

		for (int ph = 0; ph < 9; ph++) begin
			configure($urandom_range(1, 64), $urandom_range(0, 4095), $urandom_range(0, 1));
			run_phase(110);
		end

		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
